/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define HHRG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define HHRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hhrg_pkg.sv */
package hhrg_pkg;

    localparam int PAT_W       = 14;
    localparam int RANK_W      = 12;
    localparam int VALUE_W     = 18;
    localparam int CPL_W       = 16;
    localparam int TABLE_DEPTH = 1 << PAT_W;
    localparam int MAX_RESULTS = 42;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int CHAIN_SITES_DEF = 14;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // request codes on req_type
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_GENERATE = 1'b1;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_JZ_NEAR  = 2'd0;
    localparam logic [1:0] REG_JXY_NEAR = 2'd1;
    localparam logic [1:0] REG_JZ_NEXT  = 2'd2;
    localparam logic [1:0] REG_JXY_NEXT = 2'd3;

    localparam logic [CPL_W-1:0] JZ_NEAR_RST  = 16'hF000;
    localparam logic [CPL_W-1:0] JXY_NEAR_RST = 16'hF000;
    localparam logic [CPL_W-1:0] JZ_NEXT_RST  = 16'h0000;
    localparam logic [CPL_W-1:0] JXY_NEXT_RST = 16'h0000;

    typedef enum logic [1:0] {
        PH_NEAR,
        PH_NEXT,
        PH_DIAG
    } bond_phase_t;

    typedef struct packed {
        logic signed [CPL_W-1:0] jz_near;
        logic signed [CPL_W-1:0] jxy_near;
        logic signed [CPL_W-1:0] jz_next;
        logic signed [CPL_W-1:0] jxy_next;
    } coupling_t;

    typedef struct packed {
        logic                      exists;
        logic                      anti;
        logic [PAT_W-1:0]          flipped;
        logic signed [VALUE_W-1:0] diag_sum;
        logic signed [VALUE_W-1:0] off_value;
    } bond_res_t;

    typedef struct packed {
        logic              en;
        logic [PAT_W-1:0]  addr;
        logic [RANK_W-1:0] data;
    } rank_wr_t;

endpackage

/* design/hhrg_ifs.sv */
interface hhrg_item_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [hhrg_pkg::PAT_W-1:0]  state_bits;

    modport source (output valid, output req_type, output state_bits, input ready);
    modport sink   (input valid, input req_type, input state_bits, output ready);
endinterface

interface hhrg_entry_if;
    logic                               valid;
    logic                               ready;
    logic [hhrg_pkg::RANK_W-1:0]        row_index;
    logic [hhrg_pkg::RANK_W-1:0]        col_index;
    logic signed [hhrg_pkg::VALUE_W-1:0] value;
    logic                               last_of_row;

    modport source (output valid, output row_index, output col_index, output value,
                    output last_of_row, input ready);
    modport sink   (input valid, input row_index, input col_index, input value,
                    input last_of_row, output ready);
endinterface

/* design/hhrg_rank_mem.sv */
module hhrg_rank_mem
(
    input  logic                         clk,
    input  hhrg_pkg::rank_wr_t           wr,
    input  logic [hhrg_pkg::PAT_W-1:0]   rd_addr,
    output logic [hhrg_pkg::RANK_W-1:0]  rd_data
);

    logic [hhrg_pkg::RANK_W-1:0] mem [hhrg_pkg::TABLE_DEPTH];
    logic [hhrg_pkg::RANK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/hhrg_bond_unit.sv */
module hhrg_bond_unit
#(
    parameter int CHAIN_SITES = hhrg_pkg::CHAIN_SITES_DEF,
    parameter int SITE_W      = $clog2(CHAIN_SITES + 2)
)
(
    input  logic [SITE_W-1:0]                  site,
    input  hhrg_pkg::bond_phase_t              phase,
    input  logic [hhrg_pkg::PAT_W-1:0]         pat,
    input  hhrg_pkg::coupling_t                coup,
    input  logic signed [hhrg_pkg::VALUE_W-1:0] diag_acc,
    output hhrg_pkg::bond_res_t                res
);

    localparam int PW = hhrg_pkg::PAT_W;
    localparam int VW = hhrg_pkg::VALUE_W;
    localparam int CW = hhrg_pkg::CPL_W;

    logic [SITE_W-1:0]        far_site;
    logic [PW-1:0]            mask_a;
    logic [PW-1:0]            mask_b;
    logic                     spin_a;
    logic                     spin_b;
    logic signed [CW-1:0]     jz_sel;
    logic signed [CW-1:0]     jxy_sel;
    logic signed [VW-1:0]     jz_ext;
    logic signed [VW-1:0]     jxy_ext;
    logic signed [VW-1:0]     term;

    always_comb
    begin
        far_site = site + ((phase == hhrg_pkg::PH_NEXT) ? SITE_W'(2) : SITE_W'(1));
        // sites past the pattern shift out to an empty mask and read as spin down
        mask_a = PW'(1) << site;
        mask_b = PW'(1) << far_site;
        spin_a = |(pat & mask_a);
        spin_b = |(pat & mask_b);

        jz_sel  = (phase == hhrg_pkg::PH_NEXT) ? coup.jz_next  : coup.jz_near;
        jxy_sel = (phase == hhrg_pkg::PH_NEXT) ? coup.jxy_next : coup.jxy_near;
        jz_ext  = {{(VW - CW){jz_sel[CW-1]}}, jz_sel};
        jxy_ext = {{(VW - CW){jxy_sel[CW-1]}}, jxy_sel};

        res.exists = (phase != hhrg_pkg::PH_DIAG)
                     && (far_site < SITE_W'(CHAIN_SITES))
                     && ((phase == hhrg_pkg::PH_NEAR) || (coup.jz_next != '0));
        res.anti    = spin_a ^ spin_b;
        res.flipped = pat ^ mask_a ^ mask_b;

        term          = res.anti ? jz_ext : -jz_ext;
        res.diag_sum  = diag_acc + term;
        res.off_value = -{jxy_ext[VW-2:0], 1'b0};
    end

endmodule

/* design/hhrg_ctrl.sv */
module hhrg_ctrl
#(
    parameter int CHAIN_SITES = hhrg_pkg::CHAIN_SITES_DEF,
    parameter int SITE_W      = $clog2(CHAIN_SITES + 2)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    hhrg_item_if.sink                           items,
    hhrg_entry_if.source                        entries,
    output hhrg_pkg::rank_wr_t                  rank_wr,
    output logic [hhrg_pkg::PAT_W-1:0]          rank_rd_addr,
    input  logic [hhrg_pkg::RANK_W-1:0]         rank_rd_data,
    output logic [SITE_W-1:0]                   bond_site,
    output hhrg_pkg::bond_phase_t               bond_phase,
    output logic [hhrg_pkg::PAT_W-1:0]          bond_pat,
    output logic signed [hhrg_pkg::VALUE_W-1:0] bond_diag,
    input  hhrg_pkg::bond_res_t                 bond_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_BOND,
        S_LOOK
    } state_t;

    localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(CHAIN_SITES - 1);
    localparam logic [hhrg_pkg::COUNT_W-1:0] LAST_COUNT =
        hhrg_pkg::COUNT_W'(hhrg_pkg::MAX_RESULTS - 1);

    state_t                                state_reg;
    logic [SITE_W-1:0]                     site_reg;
    hhrg_pkg::bond_phase_t                 phase_reg;
    logic [hhrg_pkg::PAT_W-1:0]            pat_reg;
    logic [hhrg_pkg::RANK_W-1:0]           row_reg;
    logic signed [hhrg_pkg::VALUE_W-1:0]   diag_reg;
    logic [hhrg_pkg::COUNT_W-1:0]          count_reg;
    logic [hhrg_pkg::RANK_W-1:0]           next_rank_reg;

    logic                                  out_valid_reg;
    logic [hhrg_pkg::RANK_W-1:0]           out_row_reg;
    logic [hhrg_pkg::RANK_W-1:0]           out_col_reg;
    logic signed [hhrg_pkg::VALUE_W-1:0]   out_value_reg;
    logic                                  out_last_reg;

    logic                                  accept;
    logic                                  out_free;
    logic                                  emit;
    logic                                  cap_last;
    hhrg_pkg::bond_phase_t                 phase_next;

    always_comb
    begin
        accept     = items.valid && items.ready;
        out_free   = !out_valid_reg || entries.ready;
        emit       = out_free && (((state_reg == S_BOND) && (phase_reg == hhrg_pkg::PH_DIAG))
                                  || (state_reg == S_LOOK));
        cap_last   = (count_reg == LAST_COUNT);
        phase_next = (phase_reg == hhrg_pkg::PH_NEAR) ? hhrg_pkg::PH_NEXT : hhrg_pkg::PH_DIAG;

        rank_wr.en   = accept && (items.req_type == hhrg_pkg::REQ_REGISTER);
        rank_wr.addr = items.state_bits;
        rank_wr.data = next_rank_reg;
        // the lookup address holds steady through a stalled lookup
        rank_rd_addr = (state_reg == S_IDLE) ? items.state_bits : bond_res.flipped;
    end

    assign items.ready         = (state_reg == S_IDLE);
    assign entries.valid       = out_valid_reg;
    assign entries.row_index   = out_row_reg;
    assign entries.col_index   = out_col_reg;
    assign entries.value       = out_value_reg;
    assign entries.last_of_row = out_last_reg;

    assign bond_site  = site_reg;
    assign bond_phase = phase_reg;
    assign bond_pat   = pat_reg;
    assign bond_diag  = diag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            next_rank_reg <= '0;
            site_reg      <= '0;
            phase_reg     <= hhrg_pkg::PH_NEAR;
            count_reg     <= '0;
            pat_reg       <= '0;
            row_reg       <= '0;
            diag_reg      <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // load a new word, else drop the one just taken
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (entries.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (items.req_type == hhrg_pkg::REQ_GENERATE)
                        begin
                            pat_reg   <= items.state_bits;
                            state_reg <= S_ROW;
                        end
                        else
                        begin
                            next_rank_reg <= next_rank_reg + 1'b1;
                        end
                    end
                end

                S_ROW:
                begin
                    row_reg   <= rank_rd_data;
                    site_reg  <= '0;
                    phase_reg <= hhrg_pkg::PH_NEAR;
                    diag_reg  <= '0;
                    count_reg <= '0;
                    state_reg <= S_BOND;
                end

                S_BOND:
                begin
                    unique case (phase_reg)
                        hhrg_pkg::PH_DIAG:
                        begin
                            if (out_free)
                            begin
                                out_row_reg   <= row_reg;
                                out_col_reg   <= row_reg;
                                out_value_reg <= diag_reg;
                                out_last_reg  <= (site_reg == LAST_SITE) || cap_last;
                                count_reg     <= count_reg + 1'b1;
                                if ((site_reg == LAST_SITE) || cap_last)
                                begin
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    site_reg  <= site_reg + 1'b1;
                                    phase_reg <= hhrg_pkg::PH_NEAR;
                                    diag_reg  <= '0;
                                end
                            end
                        end

                        default:
                        begin
                            if (!bond_res.exists)
                            begin
                                phase_reg <= phase_next;
                            end
                            else
                            begin
                                diag_reg <= bond_res.diag_sum;
                                if (bond_res.anti)
                                begin
                                    state_reg <= S_LOOK;
                                end
                                else
                                begin
                                    phase_reg <= phase_next;
                                end
                            end
                        end
                    endcase
                end

                S_LOOK:
                begin
                    if (out_free)
                    begin
                        out_row_reg   <= row_reg;
                        out_col_reg   <= rank_rd_data;
                        out_value_reg <= bond_res.off_value;
                        out_last_reg  <= cap_last;
                        count_reg     <= count_reg + 1'b1;
                        if (cap_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            phase_reg <= phase_next;
                            state_reg <= S_BOND;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/heisenberg_hamiltonian_row_gen.sv */
// Sparse row generator for an open J1-J2 XXZ spin chain of CHAIN_SITES sites.
// A register word (req_type 0) stores the running rank under its 14-bit spin
// pattern in a 16384 x 12 rank table; table entries hold no value until
// written, so generate only patterns that were registered and no clearing pass
// runs after reset. A generate word (req_type 1) walks the sites in order and
// emits, per site, one entry per antiparallel nearest or next-nearest bond
// (next-nearest only while jz_next is nonzero) and then the site's diagonal
// entry, last_of_row on the final one (at most 42 entries). One shared bond
// unit evaluates one bond slot a cycle while no lookup or output stall holds
// it, and the rank table needs a registered read per lookup; the input is not
// ready while a generate word is in progress. Couplings are written over APB
// at 0x0, 0x4, 0x8 and 0xC (jz_near, jxy_near, jz_next, jxy_next, Q4.12); the
// user writes them only while idle, which the block itself does not enforce.
module heisenberg_hamiltonian_row_gen
#(
    parameter int CHAIN_SITES = hhrg_pkg::CHAIN_SITES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    hhrg_item_if.sink                         items,
    hhrg_entry_if.source                      entries,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hhrg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hhrg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hhrg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int SITE_W = $clog2(CHAIN_SITES + 2);
    localparam int CW     = hhrg_pkg::CPL_W;
    localparam int DW     = hhrg_pkg::APB_DATA_W;

    hhrg_pkg::coupling_t                 coup_reg;
    hhrg_pkg::rank_wr_t                  rank_wr;
    logic [hhrg_pkg::PAT_W-1:0]          rank_rd_addr;
    logic [hhrg_pkg::RANK_W-1:0]         rank_rd_data;
    logic [SITE_W-1:0]                   bond_site;
    hhrg_pkg::bond_phase_t               bond_phase;
    logic [hhrg_pkg::PAT_W-1:0]          bond_pat;
    logic signed [hhrg_pkg::VALUE_W-1:0] bond_diag;
    hhrg_pkg::bond_res_t                 bond_res;
    logic                                cfg_wr;
    logic [1:0]                          reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coup_reg.jz_near  <= hhrg_pkg::JZ_NEAR_RST;
            coup_reg.jxy_near <= hhrg_pkg::JXY_NEAR_RST;
            coup_reg.jz_next  <= hhrg_pkg::JZ_NEXT_RST;
            coup_reg.jxy_next <= hhrg_pkg::JXY_NEXT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                hhrg_pkg::REG_JZ_NEAR:  coup_reg.jz_near  <= pwdata[CW-1:0];
                hhrg_pkg::REG_JXY_NEAR: coup_reg.jxy_near <= pwdata[CW-1:0];
                hhrg_pkg::REG_JZ_NEXT:  coup_reg.jz_next  <= pwdata[CW-1:0];
                hhrg_pkg::REG_JXY_NEXT: coup_reg.jxy_next <= pwdata[CW-1:0];
                default:                coup_reg          <= coup_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            hhrg_pkg::REG_JZ_NEAR:  prdata = {{(DW - CW){1'b0}}, coup_reg.jz_near};
            hhrg_pkg::REG_JXY_NEAR: prdata = {{(DW - CW){1'b0}}, coup_reg.jxy_near};
            hhrg_pkg::REG_JZ_NEXT:  prdata = {{(DW - CW){1'b0}}, coup_reg.jz_next};
            hhrg_pkg::REG_JXY_NEXT: prdata = {{(DW - CW){1'b0}}, coup_reg.jxy_next};
            default:                prdata = '0;
        endcase
    end

    hhrg_rank_mem u_rank_mem
    (
        .clk     (clk),
        .wr      (rank_wr),
        .rd_addr (rank_rd_addr),
        .rd_data (rank_rd_data)
    );

    hhrg_bond_unit
    #(
        .CHAIN_SITES (CHAIN_SITES),
        .SITE_W      (SITE_W)
    )
    u_bond_unit
    (
        .site     (bond_site),
        .phase    (bond_phase),
        .pat      (bond_pat),
        .coup     (coup_reg),
        .diag_acc (bond_diag),
        .res      (bond_res)
    );

    hhrg_ctrl
    #(
        .CHAIN_SITES (CHAIN_SITES),
        .SITE_W      (SITE_W)
    )
    u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items),
        .entries      (entries),
        .rank_wr      (rank_wr),
        .rank_rd_addr (rank_rd_addr),
        .rank_rd_data (rank_rd_data),
        .bond_site    (bond_site),
        .bond_phase   (bond_phase),
        .bond_pat     (bond_pat),
        .bond_diag    (bond_diag),
        .bond_res     (bond_res)
    );

endmodule

/* design/hhrg_checker.sv */
`include "assert_macros.svh"

module hhrg_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [hhrg_pkg::RANK_W-1:0]        out_row,
    input logic [hhrg_pkg::RANK_W-1:0]        out_col,
    input logic signed [hhrg_pkg::VALUE_W-1:0] out_value,
    input logic                               out_last
);

    // a stalled word holds
    `HHRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_row) && $stable(out_col) && $stable(out_value)
        && $stable(out_last), "stalled output word changed")

    // an unfinished row keeps the input closed
    `HHRG_ASSERT_NOW(a_row_busy, out_valid && !out_last, !in_ready,
        "input ready while a row is still being emitted")

    // the input closes only after taking a word
    `HHRG_ASSERT_NOW(a_ready_drop, $fell(in_ready), $past(in_valid),
        "input ready dropped without an accepted word")

    // the row lookup keeps the first entry from following straight on an accepted word
    `HHRG_ASSERT_NEXT(a_first_gap, in_valid && in_ready, !$rose(out_valid),
        "entry emitted straight after an accepted word")

endmodule

bind heisenberg_hamiltonian_row_gen hhrg_checker u_hhrg_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (entries.valid),
    .out_ready (entries.ready),
    .out_row   (entries.row_index),
    .out_col   (entries.col_index),
    .out_value (entries.value),
    .out_last  (entries.last_of_row)
);
